// ----- rtl/skt_pkg.sv -----
// ----------------------------------------------------------------------------
// skt_pkg
// Types, sizes and codes shared by the sorted key table files.
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int KEY_W       = 32;
  localparam int PAY_W       = 32;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_DELETE = 2'd1;
  localparam logic [1:0] KIND_LOOKUP = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DUP     = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic [1:0]       kind;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [5:0]       position;
    logic [PAY_W-1:0] found_payload;
    logic [6:0]       live_count;
  } out_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

// ----- rtl/skt_ram.sv -----
// ----------------------------------------------------------------------------
// skt_ram
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module skt_ram (
  input  logic              clk,
  input  skt_pkg::mem_req_t req,
  output skt_pkg::entry_t   rdata
);

  skt_pkg::entry_t mem [skt_pkg::TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

// ----- rtl/skt_ctrl.sv -----
// ----------------------------------------------------------------------------
// skt_ctrl
// Sequencer: scans the entry store for the key, then for an insert or
// delete shifts entries up or down one at a time; builds the result.
// ----------------------------------------------------------------------------
module skt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  skt_pkg::in_t      item,
  output logic              item_stall,
  output skt_pkg::mem_req_t mem_req,
  input  skt_pkg::entry_t   rdata,
  output logic              done_valid,
  output skt_pkg::out_t     done,
  input  logic              done_take
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_SHUP   = 3'd3;
  localparam logic [2:0] S_SHDN   = 3'd4;
  localparam logic [2:0] S_WRFIN  = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]                      state;
  logic [skt_pkg::CNT_W-1:0]       count;
  skt_pkg::in_t                    op;
  logic [skt_pkg::CNT_W-1:0]       ra;
  logic                            pv;
  logic [skt_pkg::IDX_W-1:0]       pi;
  logic [skt_pkg::CNT_W-1:0]       pos;
  logic                            hit;
  logic [skt_pkg::PAY_W-1:0]       hit_payload;
  skt_pkg::out_t                   res;

  logic [skt_pkg::CNT_W-1:0] cnt_m1;
  logic [skt_pkg::CNT_W-1:0] cnt_p1;
  logic [skt_pkg::CNT_W-1:0] pos_p1;
  logic [skt_pkg::CNT_W-1:0] pi_ext;
  logic [skt_pkg::CNT_W-1:0] pi_p1;
  logic                      accept;

  assign cnt_m1 = count - 1'b1;
  assign cnt_p1 = count + 1'b1;
  assign pos_p1 = pos + 1'b1;
  assign pi_ext = skt_pkg::CNT_W'(pi);
  assign pi_p1  = pi_ext + 1'b1;
  assign accept = item_valid && !item_stall;

  assign item_stall = (state != S_IDLE);
  assign done_valid = (state == S_DONE);
  assign done       = res;

  always_comb begin
    mem_req       = '0;
    mem_req.wdata = rdata;
    unique case (state)
      S_IDLE:  mem_req.raddr = '0;
      S_SCAN:  mem_req.raddr = ra[skt_pkg::IDX_W-1:0];
      S_DECIDE: begin
        if (op.kind == skt_pkg::KIND_INSERT) begin
          mem_req.raddr = cnt_m1[skt_pkg::IDX_W-1:0];
        end else begin
          mem_req.raddr = pos_p1[skt_pkg::IDX_W-1:0];
        end
      end
      S_SHUP: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = pi_p1[skt_pkg::IDX_W-1:0];
        mem_req.raddr = pi - 1'b1;
      end
      S_SHDN: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = pi - 1'b1;
        mem_req.raddr = pi_p1[skt_pkg::IDX_W-1:0];
      end
      S_WRFIN: begin
        mem_req.we            = 1'b1;
        mem_req.waddr         = pos[skt_pkg::IDX_W-1:0];
        mem_req.wdata.key     = op.key;
        mem_req.wdata.payload = op.payload;
      end
      default: mem_req.raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pv    <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op    <= item;
            pv    <= (count != '0);
            pi    <= '0;
            ra    <= skt_pkg::CNT_W'(1);
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          // the entry read last cycle is valid when pv is set
          if (pv && rdata.key == op.key) begin
            hit         <= 1'b1;
            pos         <= pi_ext;
            hit_payload <= rdata.payload;
            state       <= S_DECIDE;
          end else if (pv && rdata.key > op.key) begin
            hit   <= 1'b0;
            pos   <= pi_ext;
            state <= S_DECIDE;
          end else if (!pv) begin
            hit   <= 1'b0;
            pos   <= count;
            state <= S_DECIDE;
          end else begin
            pv <= (ra < count);
            pi <= ra[skt_pkg::IDX_W-1:0];
            ra <= ra + 1'b1;
          end
        end
        S_DECIDE: begin
          res.found_payload <= '0;
          res.live_count    <= count[6:0];
          res.status        <= skt_pkg::ST_OK;
          res.position      <= pos[5:0];
          priority if (op.kind == skt_pkg::KIND_INSERT) begin
            if (hit) begin
              res.status <= skt_pkg::ST_DUP;
              state      <= S_DONE;
            end else if (count >= skt_pkg::DEPTH_CNT) begin
              res.status   <= skt_pkg::ST_FULL;
              res.position <= '0;
              state        <= S_DONE;
            end else if (pos == count) begin
              state <= S_WRFIN;
            end else begin
              pi    <= cnt_m1[skt_pkg::IDX_W-1:0];
              state <= S_SHUP;
            end
          end else if (op.kind == skt_pkg::KIND_DELETE) begin
            if (!hit) begin
              res.status   <= skt_pkg::ST_MISSING;
              res.position <= '0;
              state        <= S_DONE;
            end else if (pos_p1 == count) begin
              count          <= cnt_m1;
              res.live_count <= cnt_m1[6:0];
              state          <= S_DONE;
            end else begin
              pi    <= pos_p1[skt_pkg::IDX_W-1:0];
              state <= S_SHDN;
            end
          end else begin
            // unused kind behaves as a lookup
            if (hit) begin
              res.found_payload <= hit_payload;
            end else begin
              res.status   <= skt_pkg::ST_MISSING;
              res.position <= '0;
            end
            state <= S_DONE;
          end
        end
        S_SHUP: begin
          // move entry pi up one place; stop after the insertion slot
          if (pi_ext == pos) begin
            state <= S_WRFIN;
          end else begin
            pi <= pi - 1'b1;
          end
        end
        S_SHDN: begin
          if (pi_p1 == count) begin
            count          <= cnt_m1;
            res.live_count <= cnt_m1[6:0];
            state          <= S_DONE;
          end else begin
            pi <= pi_p1[skt_pkg::IDX_W-1:0];
          end
        end
        S_WRFIN: begin
          count          <= cnt_p1;
          res.live_count <= cnt_p1[6:0];
          state          <= S_DONE;
        end
        S_DONE: begin
          if (done_take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/sorted_key_table_core.sv -----
// ----------------------------------------------------------------------------
// sorted_key_table_core
// Sorted key table with insert, delete and lookup by key.
// ----------------------------------------------------------------------------
// One item is worked at a time. The scan reads one entry a cycle from
// the single read port of the entry store and stops at the first key not
// below the item's key, and an insert or delete then moves the entries
// past that point one a cycle through the same port, so scan and move
// together cover each live entry. A finished result sits in an output
// register, so the next item is taken while that result waits for its
// transfer. Reset clears the live count, the sequencer state and the
// output valid; the store itself needs no clearing pass.
module sorted_key_table_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_stall,
  input  skt_pkg::in_t  item,
  output logic          result_valid,
  input  logic          result_stall,
  output skt_pkg::out_t result
);

  skt_pkg::mem_req_t mem_req;
  skt_pkg::entry_t   rdata;
  logic              done_valid;
  skt_pkg::out_t     done;
  logic              done_take;

  skt_ram u_ram (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  skt_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_stall (item_stall),
    .mem_req    (mem_req),
    .rdata      (rdata),
    .done_valid (done_valid),
    .done       (done),
    .done_take  (done_take)
  );

  assign done_take = !result_valid || !result_stall;

  // output register: load when empty or when the held result transfers
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (done_take) begin
      result_valid <= done_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (done_take && done_valid) begin
      result <= done;
    end
  end

endmodule
